// ===== design/wdt_pkg.sv =====
package wdt_pkg;

  // Request kinds
  localparam logic [1:0] REQ_TICK  = 2'd0;
  localparam logic [1:0] REQ_READ  = 2'd1;
  localparam logic [1:0] REQ_WRITE = 2'd2;

  // Register map
  localparam logic [2:0] REG_LOAD      = 3'd0;
  localparam logic [2:0] REG_COUNTER   = 3'd1;
  localparam logic [2:0] REG_CONTROL   = 3'd2;
  localparam logic [2:0] REG_INT_STAT  = 3'd3;
  localparam logic [2:0] REG_RST_STAT  = 3'd4;
  localparam logic [2:0] REG_DISABLE   = 3'd5;

  // Control word bit positions
  localparam int CTL_ENABLE   = 0;
  localparam int CTL_AUTOLOAD = 1;
  localparam int CTL_IRQ_EN   = 2;
  localparam int CTL_WD_MODE  = 3;

  // Disable sequence words
  localparam logic [31:0] UNLOCK_WORD_A = 32'h1234_5678;
  localparam logic [31:0] UNLOCK_WORD_B = 32'h8765_4321;

  // One result word
  typedef struct packed {
    logic [31:0] read_data;
    logic        irq_pulse;
    logic        reset_flag;
  } wdt_result_t;

endpackage

// ===== design/wdt_regs.sv =====
module wdt_regs import wdt_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [1:0]  req_type,
  input  logic [2:0]  reg_index,
  input  logic [31:0] write_data,
  output wdt_result_t result
);

  logic [COUNT_WIDTH-1:0] load_value, load_value_next;
  logic [COUNT_WIDTH-1:0] count_value, count_value_next;
  logic [31:0]            control_word, control_word_next;
  logic                   int_status, int_status_next;
  logic                   reset_status, reset_status_next;
  logic                   unlock_armed, unlock_armed_next;

  logic [COUNT_WIDTH-1:0] count_dec;
  logic [31:0]            ctl_written;
  logic [31:0]            rd;
  logic                   irq;

  assign count_dec   = count_value - COUNT_WIDTH'(1);
  assign ctl_written = write_data | ({31'd0, control_word[CTL_WD_MODE]} << CTL_WD_MODE);

  // Work out the state update and result for the word at the input
  always_comb begin
    load_value_next   = load_value;
    count_value_next  = count_value;
    control_word_next = control_word;
    int_status_next   = int_status;
    reset_status_next = reset_status;
    unlock_armed_next = unlock_armed;
    rd  = '0;
    irq = 1'b0;
    case (req_type)
      REQ_TICK: begin
        if (control_word[CTL_ENABLE] &&
            (control_word[CTL_AUTOLOAD] || count_value != '0)) begin
          count_value_next = count_dec;
          if (count_dec == '0) begin
            int_status_next   = 1'b1;
            reset_status_next = 1'b1;
            irq = control_word[CTL_IRQ_EN];
            if (control_word[CTL_AUTOLOAD]) begin
              count_value_next = load_value;
            end
          end
        end
      end
      REQ_READ: begin
        case (reg_index)
          REG_LOAD:     rd = 32'(load_value);
          REG_COUNTER:  rd = 32'(count_value);
          REG_CONTROL:  rd = control_word;
          REG_INT_STAT: rd = {31'd0, int_status};
          REG_RST_STAT: rd = {31'd0, reset_status};
          default:      rd = '0;
        endcase
      end
      REQ_WRITE: begin
        case (reg_index)
          REG_LOAD:    load_value_next  = write_data[COUNT_WIDTH-1:0];
          REG_COUNTER: count_value_next = write_data[COUNT_WIDTH-1:0];
          REG_CONTROL: begin
            control_word_next = ctl_written;
            if (ctl_written[CTL_ENABLE]) begin
              count_value_next = load_value;
            end
          end
          REG_INT_STAT: begin
            if (write_data[0]) int_status_next = 1'b0;
          end
          REG_RST_STAT: begin
            if (write_data[0]) reset_status_next = 1'b0;
          end
          REG_DISABLE: begin
            if (write_data == UNLOCK_WORD_A) begin
              unlock_armed_next = 1'b1;
            end else if (write_data == UNLOCK_WORD_B && unlock_armed) begin
              control_word_next[CTL_WD_MODE] = 1'b0;
            end else begin
              unlock_armed_next = 1'b0;
            end
          end
          default: ;
        endcase
      end
      default: ;
    endcase
  end

  assign result.read_data  = rd;
  assign result.irq_pulse  = irq;
  assign result.reset_flag = reset_status_next;

  // Commit the update when a word is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      load_value   <= '0;
      count_value  <= '0;
      control_word <= '0;
      int_status   <= 1'b0;
      reset_status <= 1'b0;
      unlock_armed <= 1'b0;
    end else if (accept) begin
      load_value   <= load_value_next;
      count_value  <= count_value_next;
      control_word <= control_word_next;
      int_status   <= int_status_next;
      reset_status <= reset_status_next;
      unlock_armed <= unlock_armed_next;
    end
  end

endmodule

// ===== design/watchdog_timer_registers.sv =====
// Watchdog timer with register access: one tick, read or write per input word.
// The result word is registered, in the skid register while the output stalls.
// Throughput: one word per cycle until the skid fills; a two-entry output
// buffer (result and skid registers) keeps input open while a result waits.
// Reset: synchronous, clears all timer registers and both output entries.
module watchdog_timer_registers import wdt_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [2:0]  reg_index,
  input  logic [31:0] write_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] read_data,
  output logic        irq_pulse,
  output logic        reset_flag
);

  wdt_result_t step_result;
  wdt_result_t out_word;
  wdt_result_t skid_word;
  logic        skid_valid;
  logic        in_take;
  logic        out_take;

  assign in_stall = skid_valid;
  assign in_take  = in_valid && !in_stall;
  assign out_take = out_valid && !out_stall;

  wdt_regs #(.COUNT_WIDTH(COUNT_WIDTH)) u_regs (
    .clk        (clk),
    .rst        (rst),
    .accept     (in_take),
    .req_type   (req_type),
    .reg_index  (reg_index),
    .write_data (write_data),
    .result     (step_result)
  );

  // Output register with skid entry
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (in_take) begin
        if (out_valid && out_stall) begin
          skid_valid <= 1'b1;
          skid_word  <= step_result;
        end else begin
          out_valid <= 1'b1;
          out_word  <= step_result;
        end
      end else if (out_take) begin
        if (skid_valid) begin
          out_word   <= skid_word;
          skid_valid <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end
    end
  end

  assign read_data  = out_word.read_data;
  assign irq_pulse  = out_word.irq_pulse;
  assign reset_flag = out_word.reset_flag;

endmodule

// ===== tb/wdt_result_check.sv =====
module wdt_result_check import wdt_pkg::*; #(
  parameter int COUNT_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [2:0]  reg_index,
  input  logic [31:0] write_data,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [31:0] read_data,
  input  logic        irq_pulse,
  input  logic        reset_flag,
  output int          mismatches,
  output int          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [31:0] CNT_MASK = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  // Shadow copy of the timer registers
  logic [31:0] load_sh;
  logic [31:0] count_sh;
  logic [31:0] ctrl_sh;
  logic        int_sh;
  logic        rst_sh;
  logic        armed_sh;

  // Results still owed by the block, oldest first
  wdt_result_t owed_q[$];

  // Apply one word to the shadow registers and form its result
  task automatic run_word(input logic [1:0] kind, input logic [2:0] idx,
                          input logic [31:0] data, output wdt_result_t res);
    logic sticky;
    res = '0;
    case (kind)
      REQ_TICK: begin
        if (ctrl_sh[CTL_ENABLE] && (ctrl_sh[CTL_AUTOLOAD] || count_sh != 32'd0)) begin
          count_sh = (count_sh - 32'd1) & CNT_MASK;
          if (count_sh == 32'd0) begin
            int_sh = 1'b1;
            rst_sh = 1'b1;
            res.irq_pulse = ctrl_sh[CTL_IRQ_EN];
            if (ctrl_sh[CTL_AUTOLOAD]) count_sh = load_sh;
          end
        end
      end
      REQ_READ: begin
        case (idx)
          REG_LOAD:     res.read_data = load_sh;
          REG_COUNTER:  res.read_data = count_sh;
          REG_CONTROL:  res.read_data = ctrl_sh;
          REG_INT_STAT: res.read_data = {31'd0, int_sh};
          REG_RST_STAT: res.read_data = {31'd0, rst_sh};
          default:      res.read_data = 32'd0;
        endcase
      end
      REQ_WRITE: begin
        case (idx)
          REG_LOAD:    load_sh = data & CNT_MASK;
          REG_COUNTER: count_sh = data & CNT_MASK;
          REG_CONTROL: begin
            // watchdog mode survives any control write
            sticky = ctrl_sh[CTL_WD_MODE];
            ctrl_sh = data;
            if (sticky) ctrl_sh[CTL_WD_MODE] = 1'b1;
            if (ctrl_sh[CTL_ENABLE]) count_sh = load_sh;
          end
          REG_INT_STAT: if (data[0]) int_sh = 1'b0;
          REG_RST_STAT: if (data[0]) rst_sh = 1'b0;
          REG_DISABLE: begin
            if (data == UNLOCK_WORD_A) armed_sh = 1'b1;
            else if (data == UNLOCK_WORD_B && armed_sh) ctrl_sh[CTL_WD_MODE] = 1'b0;
            else armed_sh = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.reset_flag = rst_sh;
  endtask

  // Retire results first, then predict the word taken at this edge
  always @(posedge clk) begin
    wdt_result_t got;
    wdt_result_t want;
    if (rst) begin
      load_sh  = '0;
      count_sh = '0;
      ctrl_sh  = '0;
      int_sh   = 1'b0;
      rst_sh   = 1'b0;
      armed_sh = 1'b0;
      owed_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got.read_data  = read_data;
        got.irq_pulse  = irq_pulse;
        got.reset_flag = reset_flag;
        if (owed_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("[%0t] result word with none pending: rd=%h irq=%b rst=%b",
                     $realtime, got.read_data, got.irq_pulse, got.reset_flag);
        end else begin
          want = owed_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
              $display("[%0t] mismatch: rd exp %h got %h, irq exp %b got %b, rst exp %b got %b",
                       $realtime, want.read_data, got.read_data, want.irq_pulse,
                       got.irq_pulse, want.reset_flag, got.reset_flag);
          end
        end
      end
      if (in_valid && !in_stall) begin
        run_word(req_type, reg_index, write_data, want);
        owed_q.push_back(want);
      end
    end
    outstanding = owed_q.size();
  end

endmodule

// ===== tb/tb_watchdog_timer_registers.sv =====
module tb_watchdog_timer_registers import wdt_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_WORDS = 550;
  localparam int QUIET_TAIL   = 100;
  localparam int HOLD_AT      = 200;
  localparam int LONG_HOLD    = 300;
  localparam int DRAIN_LIMIT  = 2000;

  // Codes outside the decoded range
  localparam logic [1:0] REQ_UNKNOWN  = 2'd3;
  localparam logic [2:0] REG_UNUSED_6 = 3'd6;
  localparam logic [2:0] REG_UNUSED_7 = 3'd7;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  req_type;
  logic [2:0]  reg_index;
  logic [31:0] write_data;
  logic        out_valid;
  logic        out_stall;
  logic [31:0] read_data;
  logic        irq_pulse;
  logic        reset_flag;

  int fails;
  int pending;
  int words_sent;
  bit tx_idle_on;
  bit rx_idle_on;
  bit hold_req;

  watchdog_timer_registers #(.COUNT_WIDTH(32)) dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .reg_index(reg_index), .write_data(write_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .irq_pulse(irq_pulse), .reset_flag(reset_flag)
  );

  wdt_result_check #(.COUNT_WIDTH(32)) u_result_check (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .req_type(req_type), .reg_index(reg_index), .write_data(write_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .read_data(read_data), .irq_pulse(irq_pulse), .reset_flag(reset_flag),
    .mismatches(fails), .outstanding(pending)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop for a hung run
  initial begin
    #400_000;
    $display("Regression FAIL");
    $finish;
  end

  // Offer one word, optionally after a gap, and hold it until taken
  task automatic put_word(input logic [1:0] kind, input logic [2:0] idx,
                          input logic [31:0] data);
    bit taken;
    if (tx_idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    req_type   <= kind;
    reg_index  <= idx;
    write_data <= data;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    words_sent++;
  endtask

  // Output side: random stall bursts, one long hold-off on request
  initial begin
    out_stall <= 1'b0;
    repeat (11) @(posedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end else if (rx_idle_on && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  initial begin
    int          start_count;
    int          rand_sent;
    int          waited;
    bit          hold_done;
    logic [31:0] lv;
    logic [31:0] ctl;
    rst        <= 1'b1;
    in_valid   <= 1'b0;
    req_type   <= REQ_TICK;
    reg_index  <= REG_LOAD;
    write_data <= '0;
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    hold_req   = 1'b0;
    hold_done  = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset values, expiry with reload, status clears, sticky mode
    put_word(REQ_READ, REG_CONTROL, 32'd0);
    put_word(REQ_WRITE, REG_LOAD, 32'hFFFF_FFFF);
    put_word(REQ_WRITE, REG_CONTROL, 32'h0000_0007);
    put_word(REQ_READ, REG_COUNTER, 32'd0);
    put_word(REQ_WRITE, REG_COUNTER, 32'd1);
    put_word(REQ_TICK, REG_LOAD, 32'hFFFF_FFFF);
    put_word(REQ_READ, REG_INT_STAT, 32'd0);
    put_word(REQ_WRITE, REG_INT_STAT, 32'hFFFF_FFFE);
    put_word(REQ_WRITE, REG_INT_STAT, 32'd1);
    put_word(REQ_WRITE, REG_RST_STAT, 32'd1);
    // single shot in watchdog mode: expire, then sit at zero
    put_word(REQ_WRITE, REG_CONTROL, 32'hFFFF_FFF9);
    put_word(REQ_WRITE, REG_COUNTER, 32'd1);
    put_word(REQ_TICK, REG_COUNTER, 32'd0);
    put_word(REQ_TICK, REG_COUNTER, 32'd0);
    put_word(REQ_WRITE, REG_CONTROL, 32'd0);
    put_word(REQ_READ, REG_CONTROL, 32'd0);
    // unlock: second word alone, the full sequence, then the second word again
    put_word(REQ_WRITE, REG_DISABLE, UNLOCK_WORD_B);
    put_word(REQ_WRITE, REG_DISABLE, UNLOCK_WORD_A);
    put_word(REQ_WRITE, REG_DISABLE, UNLOCK_WORD_B);
    put_word(REQ_WRITE, REG_DISABLE, UNLOCK_WORD_B);
    put_word(REQ_READ, REG_DISABLE, 32'd0);
    // undecoded index and request type
    put_word(REQ_WRITE, REG_UNUSED_6, 32'hFFFF_FFFF);
    put_word(REQ_READ, REG_UNUSED_7, 32'd0);
    put_word(REQ_UNKNOWN, REG_CONTROL, 32'hFFFF_FFFF);
    // auto-reload from zero wraps the counter
    put_word(REQ_WRITE, REG_LOAD, 32'd0);
    put_word(REQ_WRITE, REG_CONTROL, 32'h0000_0003);
    put_word(REQ_TICK, REG_LOAD, 32'd0);

    // Random: mostly timer runs, plus status, unlock and noise words
    start_count = words_sent;
    rand_sent   = 0;
    tx_idle_on  = 1'b1;
    rx_idle_on  = 1'b1;
    while (rand_sent < RANDOM_WORDS) begin
      if (!hold_done && rand_sent >= HOLD_AT) begin
        hold_req  = 1'b1;
        hold_done = 1'b1;
      end
      if (rand_sent >= RANDOM_WORDS - QUIET_TAIL) begin
        tx_idle_on = 1'b0;
        rx_idle_on = 1'b0;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          lv = ($urandom_range(0, 9) == 0) ? $urandom : $urandom_range(0, 6);
          put_word(REQ_WRITE, REG_LOAD, lv);
          ctl = $urandom;
          ctl[CTL_ENABLE] = ($urandom_range(0, 7) != 0);
          put_word(REQ_WRITE, REG_CONTROL, ctl);
          if ($urandom_range(0, 3) == 0)
            put_word(REQ_WRITE, REG_COUNTER, $urandom_range(0, 4));
          repeat ($urandom_range(3, 15)) begin
            if ($urandom_range(0, 4) == 0)
              put_word(REQ_READ, 3'($urandom_range(0, 5)), $urandom);
            else
              put_word(REQ_TICK, 3'($urandom), $urandom);
          end
        end
        5: begin
          put_word(REQ_WRITE, ($urandom_range(0, 1) != 0) ? REG_INT_STAT : REG_RST_STAT,
                   $urandom);
          put_word(REQ_READ, REG_INT_STAT, $urandom);
          put_word(REQ_READ, REG_RST_STAT, $urandom);
        end
        6: begin
          case ($urandom_range(0, 3))
            0: begin
              put_word(REQ_WRITE, REG_DISABLE, UNLOCK_WORD_A);
              put_word(REQ_WRITE, REG_DISABLE, UNLOCK_WORD_B);
            end
            1: begin
              put_word(REQ_WRITE, REG_DISABLE, UNLOCK_WORD_A);
              put_word(REQ_WRITE, REG_DISABLE, $urandom);
              put_word(REQ_WRITE, REG_DISABLE, UNLOCK_WORD_B);
            end
            2: put_word(REQ_WRITE, REG_DISABLE, UNLOCK_WORD_B);
            default: begin
              put_word(REQ_WRITE, REG_DISABLE, UNLOCK_WORD_A);
              put_word(REQ_WRITE, REG_DISABLE, UNLOCK_WORD_B);
              put_word(REQ_WRITE, REG_DISABLE, UNLOCK_WORD_B);
            end
          endcase
          put_word(REQ_READ, REG_CONTROL, $urandom);
        end
        default: put_word(2'($urandom), 3'($urandom), $urandom);
      endcase
      rand_sent = words_sent - start_count;
    end

    // Drain, then let the output pipe settle
    in_valid <= 1'b0;
    waited = 0;
    while (pending != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    if (fails == 0 && pending == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
